@@ rtl/uia_pkg.sv @@
// ----------------------------------------------------------------------------
// Unsigned integer arithmetic unit package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package uia_pkg;

   localparam int unsigned WIDTH = 32;
   localparam int unsigned CW = $clog2(WIDTH + 1);

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_INC   = 4'd1,
      OP_SUB   = 4'd2,
      OP_DEC   = 4'd3,
      OP_MUL   = 4'd4,
      OP_DIV   = 4'd5,
      OP_MOD   = 4'd6,
      OP_POW   = 4'd7,
      OP_SQRT  = 4'd8,
      OP_LOG2  = 4'd9,
      OP_LOG10 = 4'd10,
      OP_LN    = 4'd11
   } opcode_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        error;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_LOAD  = 3'd1,
      CMD_STEP  = 3'd2,
      CMD_MSTRT = 3'd3,
      CMD_SSTRT = 3'd4,
      CMD_NEXTE = 3'd5
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic    iter_done;
      logic    need_iter;
      logic    is_pow;
      logic    exp_zero;
   } sts_type;

endpackage

@@ rtl/unsigned_integer_arith_unit.sv @@
// ----------------------------------------------------------------------------
// Unsigned integer arithmetic unit
// Add, subtract, multiply, divide, power, square root and logarithms.
// ----------------------------------------------------------------------------
// A request carries an opcode and two unsigned operands and yields exactly
// one response with a value and an error flag. Both channels use valid and
// stall; a transfer happens when valid is high and stall is low.
// The unit works on one request at a time. Add, increment, subtract and
// decrement need no iteration. Multiply, divide, modulus, log2 and ln run
// the shift-add, restoring divider or leading-one loop (divide and modulus
// by zero skip it), square root the bit-pair loop and log10 up to nine
// decade steps. Power runs one multiply and one squaring per exponent bit
// on the shared shift-add unit. The response sits in an output register;
// the next request is accepted on the edge after the result has been moved
// there. A stalled response holds until taken, and a finished result waits
// for it. Synchronous reset clears the response valid flag and returns the
// controller to idle.
// ----------------------------------------------------------------------------
module unsigned_integer_arith_unit
   import uia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type ctl;
   sts_type sts;
   rsp_type result;
   rsp_type out_ff, out_in;
   logic    capture;

   uia_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl),
      .capture   (capture)
   );

   uia_datapath u_datapath (
      .clock  (clock),
      .req    (req_data),
      .ctl    (ctl),
      .sts    (sts),
      .result (result)
   );

   assign out_in = capture ? result : out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

@@ rtl/uia_datapath.sv @@
// ----------------------------------------------------------------------------
// Unsigned integer arithmetic unit datapath
// Operand registers, shift-add multiplier, restoring divider, bit-pair
// square root, bit-serial leading-one search and decade search.
// ----------------------------------------------------------------------------
module uia_datapath
   import uia_pkg::*;
(
   input  logic    clock,
   input  req_type req,
   input  ctl_type ctl,
   output sts_type sts,
   output rsp_type result
);

   localparam logic [WIDTH-1:0] ONES = '1;
   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
   localparam logic [WIDTH-1:0] TEN = WIDTH'(10);

   logic [3:0]       kind_ff, kind_in;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] q_ff, q_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] base_ff, base_in, mul_x_ff, mul_x_in, mul_y_ff, mul_y_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic             msq_ff, msq_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] cnt_ext;
   logic [CW-2:0]    lead_idx;
   logic [WIDTH+1:0] trial;
   logic [WIDTH-1:0] ln_calc;
   logic [WIDTH-1:0] a_w, b_w;

   assign a_w = WIDTH'(req.operand_a);
   assign b_w = WIDTH'(req.operand_b);
   assign cnt_ext = WIDTH'(cnt_ff);
   assign lead_idx = (CW-1)'(WIDTH - 1) - cnt_ff[CW-2:0];
   assign trial = {rem_ff, q_ff[WIDTH-1]} - {2'b00, b_ff};

   always_comb begin
      kind_in  = kind_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      base_in  = base_ff;
      mul_x_in = mul_x_ff;
      mul_y_in = mul_y_ff;
      r_in     = r_ff;
      msq_in   = msq_ff;
      cnt_in   = cnt_ff;
      unique case (ctl.cmd)
         CMD_LOAD: begin
            kind_in = req.kind;
            a_in    = a_w;
            b_in    = b_w;
            acc_in  = '0;
            q_in    = a_w;
            rem_in  = '0;
            cnt_in  = '0;
            base_in = a_w;
            r_in    = ONE;
            msq_in  = 1'b0;
            if (req.kind == OP_SQRT) begin
               q_in = '0;
               rem_in = '0;
               acc_in = a_w;
            end
            if (req.kind == OP_LOG10) begin
               q_in = a_w;
            end
            if (req.kind == OP_MUL) begin
               mul_x_in = a_w;
               mul_y_in = b_w;
            end
         end
         CMD_MSTRT: begin
            mul_x_in = r_ff;
            mul_y_in = base_ff;
            acc_in   = '0;
            msq_in   = 1'b0;
            cnt_in   = '0;
         end
         CMD_SSTRT: begin
            if (b_ff[0]) r_in = acc_ff;
            mul_x_in = base_ff;
            mul_y_in = base_ff;
            acc_in   = '0;
            msq_in   = 1'b1;
            cnt_in   = '0;
         end
         CMD_NEXTE: begin
            base_in = acc_ff;
            b_in    = b_ff >> 1;
         end
         CMD_STEP: begin
            cnt_in = cnt_ff + CW'(1);
            priority case (kind_ff)
               OP_MUL, OP_POW: begin
                  if (mul_y_ff[0]) acc_in = acc_ff + mul_x_ff;
                  mul_x_in = mul_x_ff << 1;
                  mul_y_in = mul_y_ff >> 1;
               end
               OP_DIV, OP_MOD: begin
                  if (!trial[WIDTH+1]) begin
                     rem_in = trial[WIDTH:0];
                     q_in = {q_ff[WIDTH-2:0], 1'b1};
                  end else begin
                     rem_in = {rem_ff[WIDTH-1:0], q_ff[WIDTH-1]};
                     q_in = {q_ff[WIDTH-2:0], 1'b0};
                  end
               end
               OP_SQRT: begin
                  // Two radicand bits enter the remainder each step.
                  if ({rem_ff[WIDTH-2:0], acc_ff[WIDTH-1:WIDTH-2]} >=
                      {q_ff[WIDTH-2:0], 2'b01}) begin
                     rem_in = {rem_ff[WIDTH-2:0], acc_ff[WIDTH-1:WIDTH-2]}
                              - {q_ff[WIDTH-2:0], 2'b01};
                     q_in = {q_ff[WIDTH-2:0], 1'b1};
                  end else begin
                     rem_in = {rem_ff[WIDTH-2:0], acc_ff[WIDTH-1:WIDTH-2]};
                     q_in = {q_ff[WIDTH-2:0], 1'b0};
                  end
                  acc_in = acc_ff << 2;
               end
               OP_LOG10: begin
                  if (q_ff >= TEN) begin
                     q_in = WIDTH'((q_ff * 64'd3435973837) >> 35);
                     acc_in = acc_ff + ONE;
                  end
               end
               default: begin
                  if (a_ff[lead_idx] && acc_ff == '0 && !msq_ff)
                  begin
                     acc_in = WIDTH'(WIDTH - 1) - cnt_ext;
                     msq_in = 1'b1;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      base_ff  <= base_in;
      mul_x_ff <= mul_x_in;
      mul_y_ff <= mul_y_in;
      r_ff     <= r_in;
      msq_ff   <= msq_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      sts.is_pow    = (kind_ff == OP_POW);
      sts.exp_zero  = (b_ff == '0);
      sts.need_iter = 1'b1;
      priority case (kind_ff)
         OP_ADD, OP_INC, OP_SUB, OP_DEC: sts.need_iter = 1'b0;
         OP_DIV, OP_MOD: sts.need_iter = (b_ff != '0);
         OP_POW: sts.need_iter = 1'b0;
         default: sts.need_iter = (kind_ff <= OP_LN);
      endcase
      priority case (kind_ff)
         OP_SQRT:  sts.iter_done = (cnt_ff == CW'(WIDTH / 2));
         OP_LOG10: sts.iter_done = (q_ff < TEN);
         default:  sts.iter_done = (cnt_ff == CW'(WIDTH));
      endcase
   end

   always_comb begin
      logic [WIDTH-1:0] v;
      logic             e;
      v = '0;
      e = 1'b0;
      ln_calc = WIDTH'(((acc_ff * 7 + 5) * 64'd3435973837) >> 35);
      unique case (kind_ff)
         OP_ADD: v = a_ff + b_ff;
         OP_INC: if (a_ff == ONES) e = 1'b1; else v = a_ff + ONE;
         OP_SUB: if (a_ff < b_ff) e = 1'b1; else v = a_ff - b_ff;
         OP_DEC: if (a_ff == '0) e = 1'b1; else v = a_ff - ONE;
         OP_MUL: v = acc_ff;
         OP_DIV: if (b_ff == '0) e = 1'b1; else v = q_ff;
         OP_MOD: if (b_ff == '0) e = 1'b1; else v = rem_ff[WIDTH-1:0];
         OP_POW: v = r_ff;
         OP_SQRT: v = q_ff;
         OP_LOG2, OP_LOG10: if (a_ff == '0) e = 1'b1; else v = acc_ff;
         OP_LN: begin
            if (a_ff == '0) e = 1'b1;
            else if (a_ff <= WIDTH'(1)) v = '0;
            else if (a_ff <= WIDTH'(4)) v = WIDTH'(1);
            else if (a_ff <= WIDTH'(12)) v = WIDTH'(2);
            else if (a_ff <= WIDTH'(16)) v = WIDTH'(3);
            else v = ln_calc;
         end
         default: e = 1'b1;
      endcase
      result.value = v[31:0];
      result.error = e;
   end

endmodule

@@ rtl/uia_control.sv @@
// ----------------------------------------------------------------------------
// Unsigned integer arithmetic unit controller
// Sequences one request through the datapath and holds the response.
// ----------------------------------------------------------------------------
module uia_control
   import uia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    capture
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DISP  = 7'b0000010,
      ST_ITER  = 7'b0000100,
      ST_PMUL  = 7'b0001000,
      ST_PSQ   = 7'b0010000,
      ST_PNEXT = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl.cmd      = CMD_NONE;
      capture      = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            ctl.cmd = CMD_LOAD;
            state_in = ST_DISP;
         end
         ST_DISP: begin
            if (sts.is_pow) begin
               if (sts.exp_zero) state_in = ST_DONE;
               else begin
                  ctl.cmd = CMD_MSTRT;
                  state_in = ST_PMUL;
               end
            end else if (sts.need_iter) state_in = ST_ITER;
            else state_in = ST_DONE;
         end
         ST_ITER: begin
            if (sts.iter_done) state_in = ST_DONE;
            else ctl.cmd = CMD_STEP;
         end
         ST_PMUL: begin
            if (sts.iter_done) begin
               ctl.cmd = CMD_SSTRT;
               state_in = ST_PSQ;
            end else ctl.cmd = CMD_STEP;
         end
         ST_PSQ: begin
            if (sts.iter_done) begin
               ctl.cmd = CMD_NEXTE;
               state_in = ST_PNEXT;
            end else ctl.cmd = CMD_STEP;
         end
         ST_PNEXT: begin
            if (sts.exp_zero) state_in = ST_DONE;
            else begin
               ctl.cmd = CMD_MSTRT;
               state_in = ST_PMUL;
            end
         end
         ST_DONE: if (!rsp_valid_ff || !rsp_stall) begin
            capture = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
